/* hw/rtl/dda_pkg.sv */
// Shared types and constants of the disk drive adapter register block.
// No dependencies; dda_exec, the top level and dda_checker refer to this package.
package dda_pkg;

    typedef enum logic [2:0] {
        OP_READ   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_SCAN   = 3'd2,
        OP_FRAME  = 3'd3,
        OP_INSERT = 3'd4,
        OP_LOAD   = 3'd5,
        OP_QUERY  = 3'd6
    } t_op;

    localparam logic [4:0] OFF_LATCH_LO = 5'h00;
    localparam logic [4:0] OFF_LATCH_HI = 5'h01;
    localparam logic [4:0] OFF_IRQ_CTRL = 5'h02;
    localparam logic [4:0] OFF_DRIVE_EN = 5'h03;
    localparam logic [4:0] OFF_WR_DATA  = 5'h04;
    localparam logic [4:0] OFF_CONTROL  = 5'h05;
    localparam logic [4:0] OFF_STATUS   = 5'h10;
    localparam logic [4:0] OFF_RD_DATA  = 5'h11;
    localparam logic [4:0] OFF_DRIVE_ST = 5'h12;
    localparam logic [4:0] OFF_EXT      = 5'h13;

    localparam logic CFG_SIDE_COUNT = 1'b0;
    localparam logic CFG_SCAN_STEP  = 1'b1;

    localparam logic [3:0]  SIDE_COUNT_RESET = 4'd1;
    localparam logic [7:0]  SCAN_STEP_RESET  = 8'd113;
    localparam logic [15:0] SIDE_BYTES       = 16'd65500;
    localparam logic [15:0] HEAD_LAST        = 16'd64999;
    localparam logic [15:0] HEAD_WRITE_LIMIT = 16'd65000;
    localparam logic [7:0]  INSERT_FULL      = 8'd180;
    localparam logic [7:0]  INSERT_SETTLE    = 8'd120;
    localparam logic [7:0]  RD_NOT_READY     = 8'hFF;
    localparam logic [7:0]  RD_EXT_VALUE     = 8'h80;
    localparam logic [7:0]  RD_DRIVE_BASE    = 8'h40;
    localparam logic [1:0]  TRANSFER_START   = 2'd2;
    localparam logic [1:0]  SKIP_START       = 2'd2;
    localparam int unsigned SIDE_SPAN        = 65536;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [4:0]  reg_offset;
        logic [7:0]  data;
        logic [3:0]  side;
        logic [15:0] disk_offset;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_pulse;
        logic       mirror_update;
        logic       mirror_horizontal;
        logic       access_seen;
        logic [3:0] inserted_side;
    } t_out;

    typedef struct packed {
        logic re;
        logic we;
        logic use_q;
    } t_mem_ctl;

endpackage

/* hw/rtl/dda_mem.sv */
// Disk side storage: one write port, one read port with registered data.
// Stand-alone; sized by the parameters of the instantiating module.
module dda_mem #(
    parameter int DEPTH  = 262144,
    parameter int ADDR_W = 18
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [0:DEPTH-1];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/dda_exec.sv */
// Register file state and the single-pass update for one word.
// Uses dda_pkg; drives the storage ports of dda_mem through the top level.
module dda_exec #(
    parameter int MAX_SIDES = 4,
    parameter int ADDR_W    = 18
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  dda_pkg::t_in        i_item,
    input  logic                i_cfg_wen,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    output dda_pkg::t_out       o_res,
    output dda_pkg::t_mem_ctl   o_mem_ctl,
    output logic [ADDR_W-1:0]   o_waddr,
    output logic [7:0]          o_wdata,
    output logic [ADDR_W-1:0]   o_raddr
);

    logic [3:0]  r_side_count;
    logic [7:0]  r_scan_step;
    logic [15:0] r_irq_reload, n_irq_reload;
    logic [15:0] r_irq_count, n_irq_count;
    logic [1:0]  r_irq_mode, n_irq_mode;
    logic [1:0]  r_transfer_wait, n_transfer_wait;
    logic        r_drive_en, n_drive_en;
    logic [15:0] r_head, n_head;
    logic [1:0]  r_skip, n_skip;
    logic [1:0]  r_status, n_status;
    logic [7:0]  r_control, n_control;
    logic [3:0]  r_side_now, n_side_now;
    logic [3:0]  r_side_settled, n_side_settled;
    logic [7:0]  r_insert_timer, n_insert_timer;
    logic        r_accessed, n_accessed;

    logic        ready;
    logic        eject;
    logic [15:0] head_back;
    logic [3:0]  w_side;
    logic [15:0] w_off;

    function automatic logic in_store(input logic [3:0] sd, input logic [15:0] off);
        in_store = (sd != 4'd0) && (sd <= 4'(MAX_SIDES)) && (off < dda_pkg::SIDE_BYTES);
    endfunction

    assign ready     = (r_side_now != 4'd0) && (r_side_now == r_side_settled);
    assign eject     = !ready;
    assign head_back = r_head - 16'd2;
    assign o_raddr   = ADDR_W'({r_side_now - 4'd1, r_head});
    assign o_waddr   = ADDR_W'({w_side - 4'd1, w_off});

    always_comb begin
        n_irq_reload    = r_irq_reload;
        n_irq_count     = r_irq_count;
        n_irq_mode      = r_irq_mode;
        n_transfer_wait = r_transfer_wait;
        n_drive_en      = r_drive_en;
        n_head          = r_head;
        n_skip          = r_skip;
        n_status        = r_status;
        n_control       = r_control;
        n_side_now      = r_side_now;
        n_side_settled  = r_side_settled;
        n_insert_timer  = r_insert_timer;
        n_accessed      = r_accessed;
        o_res           = '0;
        o_mem_ctl       = '0;
        w_side          = r_side_now;
        w_off           = head_back;
        o_wdata         = i_item.data;

        case (i_item.opcode)
            dda_pkg::OP_READ: begin
                case (i_item.reg_offset)
                    dda_pkg::OFF_STATUS: begin
                        o_res.read_data = {6'd0, r_status};
                    end
                    dda_pkg::OFF_RD_DATA: begin
                        if (ready) begin
                            o_mem_ctl.use_q = in_store(r_side_now, r_head);
                            o_mem_ctl.re    = o_mem_ctl.use_q;
                            if (r_control[0]) begin
                                if (r_head < dda_pkg::HEAD_LAST) begin
                                    n_head = r_head + 16'd1;
                                end
                                n_transfer_wait = dda_pkg::TRANSFER_START;
                            end
                            n_accessed = 1'b1;
                        end else begin
                            o_res.read_data = dda_pkg::RD_NOT_READY;
                        end
                    end
                    dda_pkg::OFF_DRIVE_ST: begin
                        o_res.read_data = dda_pkg::RD_DRIVE_BASE
                            | (eject ? 8'h05 : 8'h00)
                            | ((eject || !r_control[0] || r_control[1]) ? 8'h02 : 8'h00);
                        if (r_side_settled != r_side_now
                                && r_insert_timer > dda_pkg::INSERT_SETTLE) begin
                            n_side_settled = r_side_now;
                        end
                    end
                    dda_pkg::OFF_EXT: begin
                        o_res.read_data = dda_pkg::RD_EXT_VALUE;
                    end
                    default: begin
                    end
                endcase
            end
            dda_pkg::OP_WRITE: begin
                case (i_item.reg_offset)
                    dda_pkg::OFF_LATCH_LO: n_irq_reload = {r_irq_reload[15:8], i_item.data};
                    dda_pkg::OFF_LATCH_HI: n_irq_reload = {i_item.data, r_irq_reload[7:0]};
                    dda_pkg::OFF_IRQ_CTRL: begin
                        n_irq_count = r_irq_reload;
                        n_irq_mode  = i_item.data[1:0];
                    end
                    dda_pkg::OFF_DRIVE_EN: n_drive_en = i_item.data[0];
                    dda_pkg::OFF_WR_DATA: begin
                        if (ready && r_drive_en && !r_control[2]
                                && r_head < dda_pkg::HEAD_WRITE_LIMIT) begin
                            if (r_skip != 2'd0) begin
                                n_skip = r_skip - 2'd1;
                            end else if (r_head >= 16'd2) begin
                                o_mem_ctl.we = in_store(r_side_now, head_back);
                                n_accessed   = 1'b1;
                            end
                        end
                    end
                    dda_pkg::OFF_CONTROL: begin
                        if (ready) begin
                            if (r_control[6] && !i_item.data[4] && !i_item.data[6]) begin
                                n_head = (r_head < 16'd2) ? 16'd0 : head_back;
                            end
                            if (!i_item.data[2]) begin
                                n_skip = dda_pkg::SKIP_START;
                            end
                            if (i_item.data[1]) begin
                                n_head          = 16'd0;
                                n_transfer_wait = dda_pkg::TRANSFER_START;
                            end
                            if (i_item.data[7]) begin
                                n_transfer_wait = dda_pkg::TRANSFER_START;
                            end
                        end
                        n_control               = i_item.data;
                        o_res.mirror_update     = 1'b1;
                        o_res.mirror_horizontal = i_item.data[3];
                    end
                    default: begin
                    end
                endcase
            end
            dda_pkg::OP_SCAN: begin
                n_status = 2'd0;
                if (r_irq_mode != 2'd0) begin
                    if (r_irq_count < {8'd0, r_scan_step}) begin
                        n_irq_mode      = {1'b0, r_irq_mode[0]};
                        n_irq_count     = r_irq_reload;
                        n_status        = 2'b01;
                        o_res.irq_pulse = 1'b1;
                    end else begin
                        n_irq_count = r_irq_count - {8'd0, r_scan_step};
                    end
                end else if (r_transfer_wait != 2'd0) begin
                    n_transfer_wait = r_transfer_wait - 2'd1;
                    if (r_transfer_wait == 2'd1 && r_control[7]) begin
                        n_status        = 2'b10;
                        o_res.irq_pulse = 1'b1;
                    end
                end
            end
            dda_pkg::OP_FRAME: begin
                if (r_insert_timer < dda_pkg::INSERT_FULL) begin
                    n_insert_timer = r_insert_timer + 8'd1;
                end
            end
            dda_pkg::OP_INSERT: begin
                if (i_item.side <= r_side_count) begin
                    n_side_now     = i_item.side;
                    n_insert_timer = 8'd0;
                end
            end
            dda_pkg::OP_LOAD: begin
                o_mem_ctl.we = in_store(i_item.side, i_item.disk_offset);
                w_side       = i_item.side;
                w_off        = i_item.disk_offset;
            end
            default: begin
            end
        endcase

        o_res.access_seen = n_accessed;
        if (i_item.opcode == dda_pkg::OP_QUERY) begin
            o_res.access_seen = r_accessed;
            n_accessed        = 1'b0;
        end
        o_res.inserted_side = n_side_now;
        o_mem_ctl.we        = o_mem_ctl.we & i_fire;
        o_mem_ctl.re        = o_mem_ctl.re & i_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_count <= dda_pkg::SIDE_COUNT_RESET;
            r_scan_step  <= dda_pkg::SCAN_STEP_RESET;
        end else if (i_cfg_wen) begin
            if (i_cfg_index == dda_pkg::CFG_SIDE_COUNT) begin
                r_side_count <= i_cfg_data[3:0];
            end else begin
                r_scan_step <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_reload    <= '0;
            r_irq_count     <= '0;
            r_irq_mode      <= '0;
            r_transfer_wait <= '0;
            r_drive_en      <= 1'b1;
            r_head          <= '0;
            r_skip          <= '0;
            r_status        <= '0;
            r_control       <= '0;
            r_side_now      <= 4'd1;
            r_side_settled  <= 4'd1;
            r_insert_timer  <= dda_pkg::INSERT_FULL;
            r_accessed      <= 1'b0;
        end else if (i_fire) begin
            r_irq_reload    <= n_irq_reload;
            r_irq_count     <= n_irq_count;
            r_irq_mode      <= n_irq_mode;
            r_transfer_wait <= n_transfer_wait;
            r_drive_en      <= n_drive_en;
            r_head          <= n_head;
            r_skip          <= n_skip;
            r_status        <= n_status;
            r_control       <= n_control;
            r_side_now      <= n_side_now;
            r_side_settled  <= n_side_settled;
            r_insert_timer  <= n_insert_timer;
            r_accessed      <= n_accessed;
        end
    end

endmodule

/* hw/rtl/disk_drive_adapter_registers_core.sv */
// Top level of the disk drive adapter register block.
// Uses dda_pkg, dda_exec and dda_mem.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one word per bus
//   read, bus write, scanline tick, frame tick, side insertion, disk byte load
//   or access-flag query. Output channel (o_out_valid / i_out_stall / o_out)
//   returns exactly one result word per input word, in order.
//   Configuration (i_cfg_wen / i_cfg_index / i_cfg_data) writes side_count
//   (index 0) and scanline_step (index 1); the user must write them only
//   while the block is idle, which the block itself does not enforce.
//   Throughput: one word per cycle while the output is not stalled; the input
//   register feeds the single-pass update, whose registered result and the
//   registered storage read are merged onto o_out.
//   Stall: while a result waits under i_out_stall, one more word is held in
//   the input register and o_in_stall rises only then; nothing is dropped.
//   Reset: synchronous, active low; both stages empty, registers at their
//   power-on values. Disk storage is not cleared and needs no sweep; bytes
//   read before they are loaded are undefined.
module disk_drive_adapter_registers_core #(
    parameter int MAX_SIDES = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  dda_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output dda_pkg::t_out o_out,
    input  logic          i_cfg_wen,
    input  logic          i_cfg_index,
    input  logic [7:0]    i_cfg_data
);

    localparam int DEPTH  = MAX_SIDES * dda_pkg::SIDE_SPAN;
    localparam int ADDR_W = $clog2(DEPTH);

    logic              r_in_valid;
    dda_pkg::t_in      r_in;
    logic              r_out_valid;
    dda_pkg::t_out     r_out;
    logic              r_use_q;

    logic              advance;
    logic              in_acc;
    logic              fire;
    dda_pkg::t_out     res;
    dda_pkg::t_mem_ctl mem_ctl;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        wdata;
    logic [7:0]        rdata;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign fire       = r_in_valid && advance;

    dda_exec #(
        .MAX_SIDES (MAX_SIDES),
        .ADDR_W    (ADDR_W)
    ) u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res       (res),
        .o_mem_ctl   (mem_ctl),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr)
    );

    dda_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_ctl.we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (mem_ctl.re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in;
        end
        if (fire) begin
            r_out   <= res;
            r_use_q <= mem_ctl.use_q;
        end
    end

    always_comb begin
        o_out = r_out;
        if (r_use_q) begin
            o_out.read_data = rdata;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hw/rtl/dda_checker.sv */
// Port-level checks of the disk drive adapter register block.
// Uses dda_pkg; bound to disk_drive_adapter_registers_core below.
module dda_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input dda_pkg::t_out o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result word changed while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    a_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.mirror_horizontal |-> o_out.mirror_update)
        else $error("mirroring bit without a control write");

endmodule

bind disk_drive_adapter_registers_core dda_checker u_dda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
